>>> rtl/mbirr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus input read responder package
// Shared constants, command codes and sequencer states of the responder.
// ----------------------------------------------------------------------------
package mbirr_pkg;

    localparam int MaxInputs    = 64;
    localparam int MaxRegisters = 16;

    localparam int InputIdxW = $clog2(MaxInputs);
    localparam int RegIdxW   = $clog2(MaxRegisters);

    localparam logic [15:0] InputQtyLimit = 16'h07D0;
    localparam logic [15:0] RegQtyLimit   = 16'h007D;

    localparam logic [7:0] FcReadInputs = 8'h02;
    localparam logic [7:0] FcReadRegs   = 8'h04;
    localparam logic [7:0] ExcOffset    = 8'h80;
    localparam logic [7:0] ReqDataLen   = 8'h04;

    localparam logic [7:0] ExcFunction = 8'h01;
    localparam logic [7:0] ExcAddress  = 8'h02;
    localparam logic [7:0] ExcValue    = 8'h03;

    localparam logic [1:0] CmdRequest     = 2'd0;
    localparam logic [1:0] CmdInputUpdate = 2'd1;
    localparam logic [1:0] CmdRegUpdate   = 2'd2;

    localparam logic CfgCoils     = 1'b0;
    localparam logic CfgRegisters = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HEAD,
        ST_COUNT,
        ST_DATA
    } state_t;

endpackage
`default_nettype wire

>>> rtl/modbus_input_read_responder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus input read responder
// Answers read discrete inputs and read input registers requests from stored
// sensor state, and takes updates of that state.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. An update
// transaction gives no response. A request transaction first passes the
// request check, then emits one response byte per cycle from a small
// sequencer that steps a shared adder over the stored bits or words. Each
// byte appears on response_byte in the cycle after it is formed, with
// response_valid high for exactly that cycle and last high on the final
// byte. The receiver cannot stall the responder, so it must take every byte
// in the cycle in which it is shown. A read of discrete inputs gives up to
// 10 bytes and a read of input registers up to 34.
module modbus_input_read_responder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  function_code,
    input  wire logic [7:0]  data_length,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] quantity,
    input  wire logic [5:0]  update_index,
    input  wire logic [15:0] update_value,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    output logic             response_valid,
    output logic [7:0]       response_byte,
    output logic             last
);

    mbirr_pkg::state_t state_reg, state_next;

    logic [mbirr_pkg::MaxInputs-1:0] input_bits_reg;
    logic [15:0] register_words_reg [mbirr_pkg::MaxRegisters];

    logic [6:0]  coils_in_use_reg;
    logic [4:0]  registers_in_use_reg;

    logic [7:0]  fc_reg;
    logic [7:0]  len_reg;
    logic [15:0] start_reg;
    logic [15:0] qty_reg;

    logic        error_reg, error_next;
    logic [7:0]  exc_reg, exc_next;
    logic [7:0]  count_reg, count_next;
    logic [6:0]  ptr_reg, ptr_next;
    logic [6:0]  remain_reg, remain_next;
    logic        half_reg, half_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic [16:0] add_a;
    logic [16:0] add_b;
    logic [16:0] add_sum;

    logic        accept;
    logic        is_regs;
    logic [6:0]  size_coils;
    logic [4:0]  size_regs;
    logic [16:0] size_ext;
    logic [15:0] qty_limit;
    logic [16:0] qty_plus7;
    logic [mbirr_pkg::MaxInputs-1:0] bits_shifted;
    logic [7:0]  bits_byte;
    logic [15:0] cur_word;

    assign accept  = start && !busy;
    assign busy    = (state_reg != mbirr_pkg::ST_IDLE);
    assign is_regs = (fc_reg == mbirr_pkg::FcReadRegs);

    assign response_valid = out_valid_reg;
    assign response_byte  = out_byte_reg;
    assign last           = out_last_reg;

    // The coil limit is 64 and the register limit 16, so the configured sizes clamp.
    assign size_coils = (coils_in_use_reg > 7'(mbirr_pkg::MaxInputs))
                        ? 7'(mbirr_pkg::MaxInputs) : coils_in_use_reg;
    assign size_regs  = (registers_in_use_reg > 5'(mbirr_pkg::MaxRegisters))
                        ? 5'(mbirr_pkg::MaxRegisters) : registers_in_use_reg;
    assign size_ext   = is_regs ? {12'd0, size_regs} : {10'd0, size_coils};
    assign qty_limit  = is_regs ? mbirr_pkg::RegQtyLimit : mbirr_pkg::InputQtyLimit;
    assign qty_plus7  = {1'b0, qty_reg} + 17'd7;

    // Shared adder: range sum during the check, pointer step while streaming.
    always_comb
    begin
        if (state_reg == mbirr_pkg::ST_CHECK)
        begin
            add_a = {1'b0, start_reg};
            add_b = {1'b0, qty_reg};
        end
        else
        begin
            add_a = {10'd0, ptr_reg};
            add_b = is_regs ? {16'd0, half_reg} : 17'd8;
        end
    end

    assign add_sum = add_a + add_b;

    assign bits_shifted = input_bits_reg >> ptr_reg;
    assign cur_word     = register_words_reg[ptr_reg[mbirr_pkg::RegIdxW-1:0]];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            bits_byte[k] = bits_shifted[k] && (7'(k) < remain_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        error_next     = error_reg;
        exc_next       = exc_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        remain_next    = remain_reg;
        half_next      = half_reg;
        out_valid_next = 1'b0;
        out_byte_next  = out_byte_reg;
        out_last_next  = 1'b0;

        case (state_reg)
            mbirr_pkg::ST_IDLE:
            begin
                if (accept && command == mbirr_pkg::CmdRequest)
                begin
                    state_next = mbirr_pkg::ST_CHECK;
                end
            end

            mbirr_pkg::ST_CHECK:
            begin
                error_next = 1'b1;
                if (fc_reg != mbirr_pkg::FcReadInputs && fc_reg != mbirr_pkg::FcReadRegs)
                begin
                    exc_next = mbirr_pkg::ExcFunction;
                end
                else if (len_reg != mbirr_pkg::ReqDataLen)
                begin
                    exc_next = mbirr_pkg::ExcValue;
                end
                else if (qty_reg == 16'd0 || qty_reg > qty_limit)
                begin
                    exc_next = mbirr_pkg::ExcValue;
                end
                else if (add_sum > size_ext)
                begin
                    exc_next = mbirr_pkg::ExcAddress;
                end
                else
                begin
                    error_next = 1'b0;
                    exc_next   = exc_reg;
                end
                count_next  = is_regs ? {qty_reg[6:0], 1'b0} : qty_plus7[10:3];
                ptr_next    = start_reg[6:0];
                remain_next = qty_reg[6:0];
                half_next   = 1'b0;
                state_next  = mbirr_pkg::ST_HEAD;
            end

            mbirr_pkg::ST_HEAD:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = error_reg ? (fc_reg + mbirr_pkg::ExcOffset) : fc_reg;
                state_next     = mbirr_pkg::ST_COUNT;
            end

            mbirr_pkg::ST_COUNT:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = error_reg ? exc_reg : count_reg;
                out_last_next  = error_reg;
                state_next     = error_reg ? mbirr_pkg::ST_IDLE : mbirr_pkg::ST_DATA;
            end

            mbirr_pkg::ST_DATA:
            begin
                out_valid_next = 1'b1;
                if (is_regs)
                begin
                    out_byte_next = half_reg ? cur_word[7:0] : cur_word[15:8];
                    half_next     = !half_reg;
                    ptr_next      = add_sum[6:0];
                    if (half_reg)
                    begin
                        remain_next = remain_reg - 7'd1;
                    end
                    if (half_reg && remain_reg == 7'd1)
                    begin
                        out_last_next = 1'b1;
                        state_next    = mbirr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    out_byte_next = bits_byte;
                    ptr_next      = add_sum[6:0];
                    if (remain_reg <= 7'd8)
                    begin
                        remain_next   = 7'd0;
                        out_last_next = 1'b1;
                        state_next    = mbirr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 7'd8;
                    end
                end
            end

            default:
            begin
                state_next = mbirr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= mbirr_pkg::ST_IDLE;
            out_valid_reg        <= 1'b0;
            out_last_reg         <= 1'b0;
            coils_in_use_reg     <= '0;
            registers_in_use_reg <= '0;
            input_bits_reg       <= '0;
            for (int i = 0; i < mbirr_pkg::MaxRegisters; i++)
            begin
                register_words_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (cfg_write)
            begin
                if (cfg_index == mbirr_pkg::CfgCoils)
                begin
                    coils_in_use_reg <= cfg_data;
                end
                else
                begin
                    registers_in_use_reg <= cfg_data[4:0];
                end
            end
            if (accept && command == mbirr_pkg::CmdInputUpdate)
            begin
                input_bits_reg[update_index] <= update_value[0];
            end
            if (accept && command == mbirr_pkg::CmdRegUpdate
                && update_index < 6'(mbirr_pkg::MaxRegisters))
            begin
                register_words_reg[update_index[mbirr_pkg::RegIdxW-1:0]] <= update_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fc_reg    <= function_code;
            len_reg   <= data_length;
            start_reg <= start_address;
            qty_reg   <= quantity;
        end
        error_reg    <= error_next;
        exc_reg      <= exc_next;
        count_reg    <= count_next;
        ptr_reg      <= ptr_next;
        remain_reg   <= remain_next;
        half_reg     <= half_next;
        out_byte_reg <= out_byte_next;
    end

`ifndef SYNTHESIS
    // A request transaction always starts a response sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == mbirr_pkg::CmdRequest |=> busy)
        else $error("request transaction did not start the responder");

    // The last flag only marks a byte that is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> response_valid)
        else $error("last raised without a response byte");

    // After the final byte of a response, no further byte follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && last |=> !response_valid)
        else $error("response byte emitted after the final byte");

    // Every response byte is formed while the sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid |-> $past(busy))
        else $error("response byte emitted while idle");
`endif

endmodule
`default_nettype wire

>>> verif/tb_modbus_input_read_responder_top.sv
// ----------------------------------------------------------------------------
// Testbench for the Modbus input read responder
// Drives a directed table of requests and updates and then random traffic
// under several size settings, and checks every response byte and its last
// flag against fixed bytes or a predictor of the stored inputs and registers.
// ----------------------------------------------------------------------------
module tb_modbus_input_read_responder_top;

    import mbirr_pkg::*;

    localparam logic [1:0] CmdSpare = 2'd3;

    typedef struct packed {
        logic        is_cfg;
        logic        cfg_sel;
        logic [6:0]  cfg_val;
        logic [1:0]  cmd;
        logic [7:0]  fc;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [5:0]  idx;
        logic [15:0] val;
        logic [2:0]  n_typed;
        logic [31:0] typed;
    } row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [7:0]  function_code;
    logic [7:0]  data_length;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [5:0]  update_index;
    logic [15:0] update_value;
    logic        cfg_write;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        response_valid;
    logic [7:0]  response_byte;
    logic        last;

    logic        sensor_bits [MaxInputs];
    logic [15:0] sensor_words [MaxRegisters];
    int unsigned coil_limit;
    int unsigned reg_limit;

    resp_t pending_bytes [$];
    resp_t oldest;
    row_t  directed_rows [$];
    int    fail_count;

    modbus_input_read_responder_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .function_code  (function_code),
        .data_length    (data_length),
        .start_address  (start_address),
        .quantity       (quantity),
        .update_index   (update_index),
        .update_value   (update_value),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .response_valid (response_valid),
        .response_byte  (response_byte),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_modbus_input_read_responder_top: done, errors");
        $finish;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic fin);
        resp_t r;
        r.data = data;
        r.fin  = fin;
        pending_bytes = {pending_bytes, r};
    endtask

    task automatic add_row(input row_t r);
        directed_rows = {directed_rows, r};
    endtask

    task automatic push_exception(input logic [7:0] fc, input logic [7:0] code);
        push_byte(fc + ExcOffset, 1'b0);
        push_byte(code, 1'b1);
    endtask

    task automatic compute_response(input row_t r);
        int unsigned lim;
        int unsigned first;
        int unsigned count;
        int unsigned nbytes;
        logic [7:0]  acc;
        first = r.addr;
        count = r.qty;
        case (r.cmd)
            CmdInputUpdate:
                sensor_bits[r.idx] = r.val[0];
            CmdRegUpdate:
                if (r.idx < MaxRegisters)
                    sensor_words[r.idx] = r.val;
            CmdRequest:
            begin
                if (r.fc != FcReadInputs && r.fc != FcReadRegs)
                    push_exception(r.fc, ExcFunction);
                else if (r.len != ReqDataLen)
                    push_exception(r.fc, ExcValue);
                else if (r.fc == FcReadInputs)
                begin
                    lim = (coil_limit < MaxInputs) ? coil_limit : MaxInputs;
                    if (count == 0 || count > InputQtyLimit)
                        push_exception(r.fc, ExcValue);
                    else if (first + count > lim)
                        push_exception(r.fc, ExcAddress);
                    else
                    begin
                        nbytes = (count + 7) / 8;
                        push_byte(r.fc, 1'b0);
                        push_byte(nbytes[7:0], 1'b0);
                        for (int b = 0; b < nbytes; b++)
                        begin
                            acc = '0;
                            for (int k = 0; k < 8; k++)
                                if (b * 8 + k < count)
                                    acc[k] = sensor_bits[first + b * 8 + k];
                            push_byte(acc, b == nbytes - 1);
                        end
                    end
                end
                else
                begin
                    lim = (reg_limit < MaxRegisters) ? reg_limit : MaxRegisters;
                    if (count == 0 || count > RegQtyLimit)
                        push_exception(r.fc, ExcValue);
                    else if (first + count > lim)
                        push_exception(r.fc, ExcAddress);
                    else
                    begin
                        push_byte(r.fc, 1'b0);
                        push_byte(8'(2 * count), 1'b0);
                        for (int i = 0; i < count; i++)
                        begin
                            push_byte(sensor_words[first + i][15:8], 1'b0);
                            push_byte(sensor_words[first + i][7:0], i == count - 1);
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    function automatic row_t req_row(input logic [7:0] fc, input logic [7:0] len,
                                     input logic [15:0] addr, input logic [15:0] qty,
                                     input logic [2:0] n, input logic [31:0] typed);
        row_t r;
        r = '0;
        r.cmd     = CmdRequest;
        r.fc      = fc;
        r.len     = len;
        r.addr    = addr;
        r.qty     = qty;
        r.n_typed = n;
        r.typed   = typed;
        return r;
    endfunction

    function automatic row_t upd_row(input logic [1:0] cmd, input logic [5:0] idx,
                                     input logic [15:0] val);
        row_t r;
        r = '0;
        r.cmd = cmd;
        r.fc  = FcReadInputs;
        r.len = ReqDataLen;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic which, input logic [6:0] v);
        row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_sel = which;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic int idle_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 50);
        return $urandom_range(0, 3);
    endfunction

    task automatic pause_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_responses();
        @(negedge clk);
        start <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic which, input logic [6:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= v;
        if (which == CfgCoils)
            coil_limit = v;
        else
            reg_limit = v[4:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input row_t r);
        @(negedge clk);
        start         <= 1'b1;
        command       <= r.cmd;
        function_code <= r.fc;
        data_length   <= r.len;
        start_address <= r.addr;
        quantity      <= r.qty;
        update_index  <= r.idx;
        update_value  <= r.val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.n_typed != 0)
            for (int i = 0; i < r.n_typed; i++)
                push_byte(r.typed[31 - 8 * i -: 8], i == r.n_typed - 1);
        else
            compute_response(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && response_valid)
        begin
            if (pending_bytes.size() == 0)
                note_failure($sformatf("unexpected response byte %02h last %0b",
                                       response_byte, last));
            else
            begin
                oldest = pending_bytes.pop_front();
                if (response_byte !== oldest.data || last !== oldest.fin)
                    note_failure($sformatf(
                        "response mismatch: expected %02h last %0b, got %02h last %0b",
                        oldest.data, oldest.fin, response_byte, last));
            end
        end
    end

    initial
    begin
        row_t        r;
        int          coil_plan [7];
        int          reg_plan [7];
        int unsigned span;
        int unsigned pick;
        int          gap;
        coil_plan = '{127, 0, 64, -1, 9, -1, 64};
        reg_plan  = '{31, 16, 0, -1, 1, -1, 16};
        fail_count    = 0;
        coil_limit    = 0;
        reg_limit     = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = CmdRequest;
        function_code = '0;
        data_length   = '0;
        start_address = '0;
        quantity      = '0;
        update_index  = '0;
        update_value  = '0;
        cfg_write     = 1'b0;
        cfg_index     = CfgCoils;
        cfg_data      = '0;
        foreach (sensor_bits[i])
            sensor_bits[i] = 1'b0;
        foreach (sensor_words[i])
            sensor_words[i] = '0;

        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'd1, 3'd2,
                        {FcReadInputs + ExcOffset, ExcAddress, 16'h0}));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd0, 16'd1, 3'd2,
                        {FcReadRegs + ExcOffset, ExcAddress, 16'h0}));
        add_row(cfg_row(CfgCoils, 7'd64));
        add_row(cfg_row(CfgRegisters, 7'd16));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'd1, 3'd3,
                        {FcReadInputs, 8'h01, 8'h00, 8'h00}));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd0, 16'd1, 3'd4,
                        {FcReadRegs, 8'h02, 8'h00, 8'h00}));
        add_row(upd_row(CmdInputUpdate, 6'd63, 16'hFFFF));
        add_row(upd_row(CmdInputUpdate, 6'd0, 16'h0001));
        add_row(upd_row(CmdRegUpdate, 6'd15, 16'hFFFF));
        add_row(upd_row(CmdRegUpdate, 6'd0, 16'hA55A));
        add_row(upd_row(CmdRegUpdate, 6'd63, 16'h1234));
        add_row(upd_row(CmdSpare, 6'd1, 16'h0001));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'd64, 3'd0, '0));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd0, 16'd16, 3'd0, '0));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'd0, 3'd2,
                        {FcReadInputs + ExcOffset, ExcValue, 16'h0}));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'h07D1, 3'd2,
                        {FcReadInputs + ExcOffset, ExcValue, 16'h0}));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd0, 16'h07D0, 3'd2,
                        {FcReadInputs + ExcOffset, ExcAddress, 16'h0}));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd0, 16'h007E, 3'd2,
                        {FcReadRegs + ExcOffset, ExcValue, 16'h0}));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd0, 16'h007D, 3'd2,
                        {FcReadRegs + ExcOffset, ExcAddress, 16'h0}));
        add_row(req_row(FcReadInputs, 8'hFF, 16'd0, 16'd1, 3'd2,
                        {FcReadInputs + ExcOffset, ExcValue, 16'h0}));
        add_row(req_row(8'h2B, ReqDataLen, 16'd0, 16'd1, 3'd2,
                        {8'hAB, ExcFunction, 16'h0}));
        add_row(req_row(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd2,
                        {8'h7F, ExcFunction, 16'h0}));
        add_row(req_row(8'h00, ReqDataLen, 16'd0, 16'd1, 3'd2,
                        {8'h80, ExcFunction, 16'h0}));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'hFFFF, 16'd1, 3'd2,
                        {FcReadInputs + ExcOffset, ExcAddress, 16'h0}));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'hFFFF, 16'hFFFF, 3'd2,
                        {FcReadRegs + ExcOffset, ExcValue, 16'h0}));
        add_row(req_row(FcReadInputs, ReqDataLen, 16'd63, 16'd1, 3'd0, '0));
        add_row(req_row(FcReadRegs, ReqDataLen, 16'd15, 16'd1, 3'd0, '0));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                drain_responses();
                write_cfg(directed_rows[i].cfg_sel, directed_rows[i].cfg_val);
            end
            else
                send_item(directed_rows[i]);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            drain_responses();
            write_cfg(CfgCoils, (coil_plan[ph] < 0) ? 7'($urandom_range(0, 127))
                                                    : 7'(coil_plan[ph]));
            write_cfg(CfgRegisters, (reg_plan[ph] < 0) ? 7'($urandom_range(0, 31))
                                                       : 7'(reg_plan[ph]));
            for (int k = 0; k < 40; k++)
            begin
                r = '0;
                r.addr = 16'($urandom);
                r.qty  = 16'($urandom);
                r.idx  = 6'($urandom);
                r.val  = 16'($urandom);
                r.fc   = 8'($urandom);
                r.len  = 8'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    r.cmd = CmdInputUpdate;
                else if (pick < 30)
                begin
                    r.cmd = CmdRegUpdate;
                    if ($urandom_range(0, 4) != 0)
                        r.idx = 6'($urandom_range(0, MaxRegisters - 1));
                end
                else if (pick < 88)
                begin
                    r.cmd = CmdRequest;
                    r.len = ReqDataLen;
                    r.fc  = $urandom_range(0, 1) ? FcReadInputs : FcReadRegs;
                    if (r.fc == FcReadInputs)
                        span = (coil_limit < MaxInputs) ? coil_limit : MaxInputs;
                    else
                        span = (reg_limit < MaxRegisters) ? reg_limit : MaxRegisters;
                    if (span > 0 && $urandom_range(0, 7) != 0)
                    begin
                        r.qty  = 16'($urandom_range(1, ($urandom_range(0, 3) == 0 || span < 4)
                                                          ? span : 4));
                        r.addr = 16'($urandom_range(0, span - r.qty));
                    end
                    else
                    begin
                        r.qty  = 16'($urandom_range(0, span + 2));
                        r.addr = 16'($urandom_range(0, span));
                    end
                end
                else
                begin
                    r.cmd = 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 1))
                        r.fc = $urandom_range(0, 1) ? FcReadInputs : FcReadRegs;
                end
                gap = (ph % 3 == 0) ? 0 : idle_gap();
                pause_sender(gap);
                send_item(r);
                if ($urandom_range(0, 24) == 0)
                    drain_responses();
            end
        end

        drain_responses();
        repeat (40) @(posedge clk);
        while (pending_bytes.size() != 0)
        begin
            oldest = pending_bytes.pop_front();
            note_failure($sformatf("missing response byte %02h last %0b",
                                   oldest.data, oldest.fin));
        end
        if (fail_count == 0)
            $display("tb_modbus_input_read_responder_top: done, clean");
        else
            $display("tb_modbus_input_read_responder_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/mbirr_pkg.sv
rtl/modbus_input_read_responder_top.sv
verif/tb_modbus_input_read_responder_top.sv
